FILE: hw/rtl/dwu_pkg.sv
// Shared types and constants for the data watchpoint unit.
package dwu_pkg;

    localparam int MAX_WATCHPOINTS = 8;
    localparam int CNT_W           = $clog2(MAX_WATCHPOINTS + 1);
    localparam int ADDR_W          = 32;
    localparam int END_W           = ADDR_W + 1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int PADDR_W   = 3;

    localparam logic [0:0] REG_SUPPRESS_CHECKS = 1'd0;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TAKE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [END_W-1:0]  stop;      // start + length, exclusive
        logic              trig_rd;
        logic              trig_wr;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] chk_addr;
        logic [END_W-1:0]  chk_end;
        logic              chk_write;
        logic [ADDR_W-1:0] rm_addr;
    } req_t;

    typedef struct packed {
        logic occupied;
        logic load;
        logic check_en;
        logic rm_step;
    } cell_ctrl_t;

    typedef struct packed {
        logic              hit_seen;
        logic [ADDR_W-1:0] hit_start;
        logic              rm_seen;
    } chain_t;

    typedef struct packed {
        logic [3:0]        removed_count;
        logic              add_accepted;
        logic              taken;
        logic              hit_dir_wr;
        logic [ADDR_W-1:0] hit_address;
        logic              hit_pending;
    } res_t;

endpackage

FILE: hw/rtl/dwu_cell.sv
// One watchpoint slot: holds an entry, matches requests, shifts from its neighbor.
module dwu_cell
(
    input  logic                clk,
    input  dwu_pkg::cell_ctrl_t ctrl,
    input  dwu_pkg::req_t       req,
    input  dwu_pkg::entry_t     new_entry,
    input  dwu_pkg::entry_t     next_entry,
    input  dwu_pkg::chain_t     chain_in,
    output dwu_pkg::entry_t     entry,
    output dwu_pkg::chain_t     chain_out
);
    import dwu_pkg::*;

    entry_t entry_reg;
    logic   overlap;
    logic   dir_ok;
    logic   hit_here;
    logic   rm_here;
    logic   shift;

    assign overlap  = ({1'b0, req.chk_addr} < entry_reg.stop) &&
                      ({1'b0, entry_reg.start} < req.chk_end);
    assign dir_ok   = req.chk_write ? entry_reg.trig_wr : entry_reg.trig_rd;
    assign hit_here = ctrl.occupied && ctrl.check_en && overlap && dir_ok;
    assign rm_here  = ctrl.occupied && (entry_reg.start == req.rm_addr);

    always_comb
    begin
        chain_out.hit_seen  = chain_in.hit_seen | hit_here;
        chain_out.hit_start = (hit_here && !chain_in.hit_seen) ? entry_reg.start
                                                                : chain_in.hit_start;
        chain_out.rm_seen   = chain_in.rm_seen | rm_here;
    end

    // everything from the first matching slot upward moves down by one
    assign shift = ctrl.rm_step && chain_out.rm_seen;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= new_entry;
        end
        else if (shift)
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: hw/rtl/data_watchpoint_unit.sv
// Top level of the data watchpoint unit: request handling, result buffer, APB register.
//
// Watchpoints sit in a row of slots, lowest slot first in table order. An access check,
// an add or a take-hit request is accepted and its result is registered, into the output
// register or, while the output is stalled, into a one-result hold buffer; back-to-back
// such requests go at one per cycle while the output drains. A remove request deletes
// every entry whose start matches: the row deletes one matching slot per cycle by
// shifting the slots above it down by one, and a last pass finds no further match. Input
// is held off during a remove. Writes to suppress_checks are taken at any time through
// the APB port but are meant to be done while idle.
module data_watchpoint_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: op[1:0], address[33:2], span[65:34], wr_access[66],
    //          watch_reads[67], watch_writes[68], zero pad[71:69]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dwu_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: hit_pending[0], hit_address[32:1], hit_dir_wr[33], taken[34],
    //          add_accepted[35], removed_count[39:36]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dwu_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dwu_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dwu_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_REMOVE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic                hit_latched_reg;
    logic [ADDR_W-1:0]   hit_start_reg;
    logic                hit_write_reg;
    logic [ADDR_W-1:0]   rm_addr_reg;
    logic [CNT_W-1:0]    gone_reg;
    logic                suppress_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic                hold_valid_reg;
    res_t                hold_res_reg;

    op_t                 in_op;
    logic [ADDR_W-1:0]   in_address;
    logic [ADDR_W-1:0]   in_span;
    logic                in_wr_access;
    logic                in_watch_reads;
    logic                in_watch_writes;

    logic                in_fire;
    logic                out_take;
    logic                check_en;
    logic                add_en;
    logic                rm_step;
    logic                rm_any;
    logic                finish;
    logic                new_hit;
    logic                take_hit;
    logic                hit_latched_next;
    logic [ADDR_W-1:0]   hit_start_next;
    logic                hit_write_next;
    res_t                res;
    req_t                req;
    entry_t              new_entry;
    logic                cfg_write;

    entry_t              entries [MAX_WATCHPOINTS+1];
    chain_t              chain   [MAX_WATCHPOINTS+1];

    assign in_op           = op_t'(s_tdata[1:0]);
    assign in_address      = s_tdata[33:2];
    assign in_span         = s_tdata[65:34];
    assign in_wr_access    = s_tdata[66];
    assign in_watch_reads  = s_tdata[67];
    assign in_watch_writes = s_tdata[68];

    assign s_tready = (state_reg == ST_IDLE) && !hold_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    assign check_en = in_fire && (in_op == OP_CHECK) && !suppress_reg && !hit_latched_reg;
    assign add_en   = in_fire && (in_op == OP_ADD) &&
                      (entry_count_reg < CNT_W'(MAX_WATCHPOINTS));
    assign take_hit = in_fire && (in_op == OP_TAKE) && hit_latched_reg;
    assign rm_step  = (state_reg == ST_REMOVE);

    always_comb
    begin
        req.chk_addr  = in_address;
        req.chk_end   = {1'b0, in_address} + {1'b0, in_span};
        req.chk_write = in_wr_access;
        req.rm_addr   = rm_addr_reg;

        new_entry.start   = in_address;
        new_entry.stop    = {1'b0, in_address} +
                            ((in_span == '0) ? END_W'(1) : {1'b0, in_span});
        new_entry.trig_rd = in_watch_reads;
        new_entry.trig_wr = in_watch_writes;
    end

    assign chain[0] = '0;
    assign entries[MAX_WATCHPOINTS] = '0;

    for (genvar i = 0; i < MAX_WATCHPOINTS; i++)
    begin : g_cell
        cell_ctrl_t ctrl;

        always_comb
        begin
            ctrl.occupied = CNT_W'(i) < entry_count_reg;
            ctrl.load     = add_en && (entry_count_reg == CNT_W'(i));
            ctrl.check_en = check_en;
            ctrl.rm_step  = rm_step;
        end

        dwu_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .req        (req),
            .new_entry  (new_entry),
            .next_entry (entries[i+1]),
            .chain_in   (chain[i]),
            .entry      (entries[i]),
            .chain_out  (chain[i+1])
        );
    end

    assign new_hit = chain[MAX_WATCHPOINTS].hit_seen;
    assign rm_any  = chain[MAX_WATCHPOINTS].rm_seen;
    assign finish  = (in_fire && (in_op != OP_REMOVE)) || (rm_step && !rm_any);

    always_comb
    begin
        hit_latched_next = hit_latched_reg;
        hit_start_next   = hit_start_reg;
        hit_write_next   = hit_write_reg;
        if (new_hit)
        begin
            hit_latched_next = 1'b1;
            hit_start_next   = chain[MAX_WATCHPOINTS].hit_start;
            hit_write_next   = in_wr_access;
        end
        else if (take_hit)
        begin
            hit_latched_next = 1'b0;
        end

        res.hit_pending   = hit_latched_next;
        res.hit_address   = (hit_latched_next || take_hit) ? hit_start_next : '0;
        res.hit_dir_wr    = (hit_latched_next || take_hit) ? hit_write_next : 1'b0;
        res.taken         = take_hit;
        res.add_accepted  = add_en;
        res.removed_count = rm_step ? 4'(gone_reg) : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            hit_latched_reg <= 1'b0;
            hit_start_reg   <= '0;
            hit_write_reg   <= 1'b0;
            rm_addr_reg     <= '0;
            gone_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_res_reg     <= '0;
            hold_valid_reg  <= 1'b0;
            hold_res_reg    <= '0;
        end
        else
        begin
            hit_latched_reg <= hit_latched_next;
            hit_start_reg   <= hit_start_next;
            hit_write_reg   <= hit_write_next;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (in_op == OP_REMOVE))
                    begin
                        state_reg   <= ST_REMOVE;
                        rm_addr_reg <= in_address;
                        gone_reg    <= '0;
                    end
                    if (add_en)
                    begin
                        entry_count_reg <= entry_count_reg + CNT_W'(1);
                    end
                end
                ST_REMOVE:
                begin
                    if (rm_any)
                    begin
                        entry_count_reg <= entry_count_reg - CNT_W'(1);
                        gone_reg        <= gone_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // two-deep result buffer; hold fills only while the output is stalled
            if (out_take)
            begin
                if (hold_valid_reg)
                begin
                    out_res_reg    <= hold_res_reg;
                    hold_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= finish;
                    out_res_reg   <= res;
                end
            end
            else if (finish)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_res_reg   <= res;
                end
                else
                begin
                    hold_valid_reg <= 1'b1;
                    hold_res_reg   <= res;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_SUPPRESS_CHECKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suppress_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            suppress_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_SUPPRESS_CHECKS) ? {31'd0, suppress_reg} : 32'd0;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_WATCHPOINTS))
        else $error("entry count above table depth");

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("buffered result without output result");

    a_remove_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |-> !s_tready)
        else $error("request accepted during remove");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.taken && out_res_reg.hit_pending))
        else $error("taken hit still reported pending");

    a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_latched_reg && !(in_fire && (in_op == OP_TAKE))) |=> hit_latched_reg)
        else $error("hit latch lost without a take");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking stream/APB testbench for the data watchpoint unit.
module testbench;
    import dwu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [0:0] REG_SPARE = 1'd1;   // index past the register list
    localparam logic [PADDR_W-1:0] SUPPRESS_ADDR = {REG_SUPPRESS_CHECKS, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR    = {REG_SPARE, 2'b00};
    localparam res_t QUIET_RESULT = '0;

    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [31:0] span;
        logic        wr_access;
        logic        watch_reads;
        logic        watch_writes;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     known;
        res_t     want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predicted watchpoint table and hit latch
    logic [31:0] wp_start [MAX_WATCHPOINTS];
    logic [31:0] wp_len [MAX_WATCHPOINTS];
    logic        wp_trig_rd [MAX_WATCHPOINTS];
    logic        wp_trig_wr [MAX_WATCHPOINTS];
    int unsigned wp_count = 0;
    logic        latched = 1'b0;
    logic [31:0] latched_start = '0;
    logic        latched_write = 1'b0;
    logic        suppressed = 1'b0;

    res_t        pending_results [$];
    stim_row_t   opening_rows [$];
    int          requests_sent = 0;
    int          errors = 0;
    bit          calm = 1'b0;

    data_watchpoint_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic res_t outcome(logic pend, logic [31:0] addr, logic on_wr, logic tk,
                                     logic added, logic [3:0] removed);
        res_t o;
        o.hit_pending   = pend;
        o.hit_address   = addr;
        o.hit_dir_wr    = on_wr;
        o.taken         = tk;
        o.add_accepted  = added;
        o.removed_count = removed;
        return o;
    endfunction

    function automatic request_t make_request(op_t op, logic [31:0] address, logic [31:0] span,
                                              logic wr_access, logic watch_reads,
                                              logic watch_writes);
        request_t r;
        r.op           = op;
        r.address      = address;
        r.span         = span;
        r.wr_access    = wr_access;
        r.watch_reads  = watch_reads;
        r.watch_writes = watch_writes;
        return r;
    endfunction

    function automatic stim_row_t row(request_t req, logic known = 1'b0,
                                      res_t want = QUIET_RESULT);
        stim_row_t s;
        s.req   = req;
        s.known = known;
        s.want  = want;
        return s;
    endfunction

    // Applies one request to the predicted table and returns the result it should produce.
    function automatic res_t watch_outcome(request_t r);
        res_t        o;
        logic [32:0] acc_end;
        logic [32:0] ent_end;
        int unsigned keep;
        int unsigned gone;
        o = '0;
        case (r.op)
            OP_CHECK:
            begin
                if (!suppressed && !latched)
                begin
                    acc_end = {1'b0, r.address} + {1'b0, r.span};
                    for (int i = 0; i < wp_count; i++)
                    begin
                        ent_end = {1'b0, wp_start[i]} + {1'b0, wp_len[i]};
                        if ({1'b0, r.address} < ent_end && {1'b0, wp_start[i]} < acc_end &&
                            (r.wr_access ? wp_trig_wr[i] : wp_trig_rd[i]))
                        begin
                            latched       = 1'b1;
                            latched_start = wp_start[i];
                            latched_write = r.wr_access;
                            break;
                        end
                    end
                end
            end
            OP_ADD:
            begin
                if (wp_count < MAX_WATCHPOINTS)
                begin
                    wp_start[wp_count]   = r.address;
                    wp_len[wp_count]     = (r.span == 0) ? 32'd1 : r.span;
                    wp_trig_rd[wp_count] = r.watch_reads;
                    wp_trig_wr[wp_count] = r.watch_writes;
                    wp_count++;
                    o.add_accepted = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                keep = 0;
                gone = 0;
                for (int i = 0; i < wp_count; i++)
                begin
                    if (wp_start[i] == r.address)
                        gone++;
                    else
                    begin
                        wp_start[keep]   = wp_start[i];
                        wp_len[keep]     = wp_len[i];
                        wp_trig_rd[keep] = wp_trig_rd[i];
                        wp_trig_wr[keep] = wp_trig_wr[i];
                        keep++;
                    end
                end
                wp_count = keep;
                o.removed_count = gone[3:0];
            end
            default:
            begin
                if (latched)
                begin
                    o.taken        = 1'b1;
                    o.hit_address  = latched_start;
                    o.hit_dir_wr   = latched_write;
                    latched        = 1'b0;
                end
            end
        endcase
        if (latched)
        begin
            o.hit_address = latched_start;
            o.hit_dir_wr  = latched_write;
        end
        o.hit_pending = latched;
        return o;
    endfunction

    function automatic logic [31:0] hot_base(int k);
        case (k)
            0:       return 32'h0000_0100;
            1:       return 32'h0000_0104;
            2:       return 32'h8000_2000;
            default: return 32'hFFFF_FFF0;
        endcase
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic request_t pick_request();
        request_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        r.op = (roll < 45) ? OP_CHECK : (roll < 65) ? OP_ADD : (roll < 78) ? OP_REMOVE : OP_TAKE;
        r.wr_access    = 1'($urandom_range(0, 1));
        r.watch_reads  = 1'($urandom_range(0, 1));
        r.watch_writes = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7)
            r.address = hot_base($urandom_range(0, 3)) +
                        ((r.op == OP_CHECK) ? $urandom_range(0, 24) - 32'd4 : 32'd0);
        else
            r.address = any_word();
        // removes mostly aim at a start that is in the table
        if (r.op == OP_REMOVE && wp_count != 0 && $urandom_range(0, 1) == 1)
            r.address = wp_start[$urandom_range(0, wp_count - 1)];
        roll = $urandom_range(0, 9);
        case (r.op)
            OP_CHECK: r.span = (roll < 7) ? $urandom_range(1, 4) : (roll < 8) ? 32'd0 : any_word();
            OP_ADD:   r.span = (roll < 8) ? $urandom_range(0, 16) : any_word();
            default:  r.span = $urandom();
        endcase
        return r;
    endfunction

    function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Offers one request on the input stream; called just after a rising edge.
    task automatic offer(request_t r, logic known, res_t want);
        res_t p;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.watch_writes, r.watch_reads, r.wr_access, r.span, r.address, r.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = watch_outcome(r);
        pending_results.insert(pending_results.size(), known ? want : p);
        requests_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write followed by a readback of suppress_checks.
    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == SUPPRESS_ADDR)
            suppressed = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SUPPRESS_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== suppressed)
        begin
            $display("%0t: suppress_checks readback expected %0d got %0d",
                     $time, suppressed, prdata[0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int count, bit quiet_tail);
        logic [31:0] base;
        logic        rd;
        logic        wr;
        for (int i = 0; i < count; i++)
        begin
            if (quiet_tail && i == count - 80)
                calm = 1'b1;
            if (i == 10 || $urandom_range(0, 79) == 0)
            begin
                // empty the table, stack a full table on one start, then drop it all at once
                while (wp_count != 0)
                    offer(make_request(OP_REMOVE, wp_start[0], $urandom(), 0, 0, 0), 1'b0, '0);
                base = hot_base($urandom_range(0, 3));
                rd = 1'($urandom_range(0, 1));
                wr = !rd || ($urandom_range(0, 1) != 0);
                repeat (MAX_WATCHPOINTS)
                    offer(make_request(OP_ADD, base, $urandom_range(0, 16), 0, rd, wr), 1'b0, '0);
                offer(make_request(OP_REMOVE, base, 32'h0, 0, 0, 0), 1'b0, '0);
            end
            offer(pick_request(), 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result expected none got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                note_field("hit_pending", 32'(want.hit_pending), 32'(got.hit_pending));
                note_field("hit_address", want.hit_address, got.hit_address);
                note_field("hit_dir_wr", 32'(want.hit_dir_wr), 32'(got.hit_dir_wr));
                note_field("taken", 32'(want.taken), 32'(got.taken));
                note_field("add_accepted", 32'(want.add_accepted), 32'(got.add_accepted));
                note_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
            end
        end
    end

    // receiver pacing, with one long hold-off so the block backs up into its input
    initial
    begin : sink_pace
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && requests_sent >= 120)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (40) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[data_watchpoint_unit] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        opening_rows = {
            row(make_request(OP_TAKE, 32'h0, 32'h0, 0, 0, 0), 1'b1, QUIET_RESULT),
            row(make_request(OP_CHECK, 32'h0, 32'h4, 0, 0, 0), 1'b1, QUIET_RESULT),
            row(make_request(OP_REMOVE, 32'h0, 32'h0, 0, 0, 0), 1'b1, QUIET_RESULT),
            row(make_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1), 1'b1,
                outcome(0, 32'h0, 0, 0, 1, 0)),
            // top of the address space: the sums must not wrap
            row(make_request(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0), 1'b1,
                outcome(1, 32'hFFFF_FFFF, 1, 0, 0, 0)),
            row(make_request(OP_CHECK, 32'h0, 32'h4, 0, 0, 0)),
            row(make_request(OP_TAKE, 32'h0, 32'h0, 0, 0, 0), 1'b1,
                outcome(0, 32'hFFFF_FFFF, 1, 1, 0, 0)),
            row(make_request(OP_ADD, 32'h1000, 32'h0, 1, 1, 0), 1'b1,
                outcome(0, 32'h0, 0, 0, 1, 0)),
            row(make_request(OP_CHECK, 32'h1000, 32'h0, 0, 0, 0)),
            row(make_request(OP_CHECK, 32'h0FFF, 32'h2, 1, 0, 0)),
            row(make_request(OP_CHECK, 32'h0FFF, 32'h2, 0, 0, 0)),
            row(make_request(OP_TAKE, 32'h0, 32'h0, 0, 0, 0)),
            row(make_request(OP_ADD, 32'h2000, 32'h10, 0, 0, 1)),
            // zero-size access strictly inside an entry
            row(make_request(OP_CHECK, 32'h2008, 32'h0, 1, 0, 0)),
            row(make_request(OP_TAKE, 32'h0, 32'h0, 0, 0, 0)),
            row(make_request(OP_CHECK, 32'h2010, 32'h4, 1, 0, 0)),
            row(make_request(OP_CHECK, 32'h0, 32'hFFFF_FFFF, 0, 0, 0)),
            row(make_request(OP_TAKE, 32'h0, 32'h0, 0, 0, 0)),
            row(make_request(OP_ADD, 32'h1000, 32'h8, 0, 1, 1)),
            row(make_request(OP_ADD, 32'h1000, 32'h8, 0, 1, 1)),
            row(make_request(OP_ADD, 32'h1000, 32'h8, 0, 1, 1)),
            row(make_request(OP_ADD, 32'h1000, 32'h8, 0, 1, 1)),
            row(make_request(OP_ADD, 32'h3000, 32'h4, 0, 1, 0)),
            // table full: refused
            row(make_request(OP_ADD, 32'h4000, 32'h4, 0, 1, 1), 1'b1, QUIET_RESULT),
            row(make_request(OP_REMOVE, 32'h1000, 32'h0, 0, 0, 0))
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_write(SUPPRESS_ADDR, 32'd0);
        foreach (opening_rows[k])
            offer(opening_rows[k].req, opening_rows[k].known, opening_rows[k].want);
        random_phase(200, 1'b0);
        settle();

        reg_write(SUPPRESS_ADDR, 32'd1);
        random_phase(80, 1'b0);
        settle();

        reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
        reg_write(SUPPRESS_ADDR, 32'd0);
        random_phase(200, 1'b1);
        settle();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[data_watchpoint_unit] OK");
        else
            $display("[data_watchpoint_unit] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dwu_pkg.sv
hw/rtl/dwu_cell.sv
hw/rtl/data_watchpoint_unit.sv
tb/sv/testbench.sv
